// ----- rtl/qbf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quartic bond unit.
// No dependencies; imported by every module of the block.
package qbf_pkg;

  // Limb width of the partial-product multiplier
  localparam int LIMB_W = 32;

  // Saturation limit of the wide intermediates, 2^62
  localparam logic [62:0] LIM62 = 63'h4000_0000_0000_0000;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_HARMONIC = 2'd0;
  localparam logic [1:0] CFG_QUARTIC  = 2'd1;
  localparam logic [1:0] CFG_REST     = 2'd2;
  localparam logic [1:0] CFG_CUTOFF   = 2'd3;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
  } qbf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] bond_energy;
    logic               bond_broken;
  } qbf_out_t;

  // Magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  // Round p / 2^s to nearest, ties away from zero, clamp to 2^62
  function automatic logic [62:0] round_sat(input logic [127:0] p, input logic [5:0] s);
    logic [127:0] t;
    t = (p + (128'(1) << (s - 6'd1))) >> s;
    if (t > 128'(LIM62)) begin
      return LIM62;
    end
    return t[62:0];
  endfunction

  // Sign and magnitude to 65-bit two's complement
  function automatic logic signed [64:0] to_s65(input logic neg, input logic [62:0] m);
    return neg ? -$signed(65'(m)) : $signed(65'(m));
  endfunction

endpackage

// ----- rtl/qbf_mul.sv -----
// Pipelined unsigned multiplier built from 32x32 limb products.
// Depends on qbf_pkg; three register stages, advances on en.
module qbf_mul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);
  import qbf_pkg::*;

  localparam int NA = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int PW = A_W + B_W;

  logic [NA*LIMB_W-1:0] a_ext;
  logic [NB*LIMB_W-1:0] b_ext;
  logic [2*LIMB_W-1:0]  pp [NA][NB];
  logic [PW-1:0]        row_sum [NA];
  logic [PW-1:0]        row [NA];
  logic [PW-1:0]        p_next;

  assign a_ext = (NA*LIMB_W)'(a);
  assign b_ext = (NB*LIMB_W)'(b);

  // Form limb products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  // Sum each row of limb products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_sum[i] = row_sum[i] + (PW'(pp[i][j]) << (j*LIMB_W));
      end
    end
  end

  // Combine the rows
  always_comb begin
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] << (i*LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row <= row_sum;
      p   <= p_next;
    end
  end

endmodule

// ----- rtl/quartic_bond_force_energy_unit.sv -----
// Top level of the quartic bond force and energy unit.
// Depends on qbf_pkg and qbf_mul.
//
// Takes one separation vector per cycle and returns force and energy for it
// at the end of the pipeline; throughput is one item per clock while the result side
// takes items. The pipeline depth is set by the square root (16 stages, two result
// bits each), the chain of rounded products (dr^2, dr^3, k1*dr^3, four
// stages each) and the per-component divider (16 stages, two quotient bits
// each). A stall on the result side holds the whole pipeline. Configuration
// writes are taken at any time but must only be made while the unit is empty.
module quartic_bond_force_energy_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  qbf_pkg::qbf_in_t item,
  output logic             result_valid,
  input  logic             result_ready,
  output qbf_pkg::qbf_out_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_addr,
  input  logic [31:0]      cfg_data
);
  import qbf_pkg::*;

  // Stage positions
  localparam int ST_SUM      = 2;
  localparam int ST_SQRT0    = 3;
  localparam int SQRT_PER    = 2;
  localparam int SQRT_STAGES = 32 / SQRT_PER;
  localparam int ST_DIST     = ST_SQRT0 + SQRT_STAGES;
  localparam int ST_DR       = ST_DIST + 1;
  localparam int MUL_LAT     = 3;
  localparam int ST_M1       = ST_DR + MUL_LAT + 1;
  localparam int ST_M2       = ST_M1 + MUL_LAT + 1;
  localparam int ST_M3       = ST_M2 + MUL_LAT + 1;
  localparam int ST_NUM      = ST_M3 + 1;
  localparam int ST_PADD     = ST_NUM + MUL_LAT + 1;
  localparam int ST_SAT      = ST_PADD + 1;
  localparam int ST_DIV0     = ST_SAT + 1;
  localparam int DIV_PER     = 2;
  localparam int DIV_STAGES  = 32 / DIV_PER;
  localparam int LAST        = ST_DIV0 + DIV_STAGES;

  localparam logic [5:0] SH0 = 6'(FRAC_BITS);
  localparam logic [5:0] SH1 = 6'(FRAC_BITS + 1);
  localparam logic [5:0] SH2 = 6'(FRAC_BITS + 2);

  typedef struct packed {
    logic [2:0][31:0] sep;
    logic [2:0][63:0] sq;
    logic [61:0]      cut2;
    logic             cut_on;
    logic [63:0]      d2;
    logic             broken;
    logic [63:0]      sx;
    logic [63:0]      sres;
    logic [31:0]      dlen;
    logic             dist_zero;
    logic             dr_neg;
    logic [31:0]      dr_mag;
    logic             t1_neg;
    logic [62:0]      t1_mag;
    logic [62:0]      dr2_mag;
    logic             dr3_neg;
    logic [62:0]      dr3_mag;
    logic [62:0]      dr4_mag;
    logic             e1_neg;
    logic [62:0]      e1_mag;
    logic             t2_neg;
    logic [62:0]      t2_mag;
    logic             e2_neg;
    logic [62:0]      e2_mag;
    logic             num_neg;
    logic [62:0]      num_mag;
    logic [31:0]      energy;
    logic [2:0][95:0] pf;
    logic [2:0]       sat;
    logic [2:0][31:0] rem;
    logic [2:0][31:0] low;
    logic [2:0][31:0] quo;
    logic [2:0][31:0] frc;
  } stage_t;

  logic signed [31:0] harmonic_gain;
  logic signed [31:0] quartic_gain;
  logic [30:0]        rest_length;
  logic [30:0]        cutoff_length;

  stage_t      pipe [1:LAST];
  stage_t      nxt  [1:LAST];
  logic [1:LAST] vld;
  logic        adv;

  logic [63:0]  p_t1, p_dr2;
  logic [94:0]  p_dr3, p_e1, p_t2, p_e2;
  logic [125:0] p_dr4;
  logic [94:0]  p_f [3];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_gain <= '0;
      quartic_gain  <= '0;
      rest_length   <= '0;
      cutoff_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_HARMONIC: harmonic_gain <= cfg_data;
        CFG_QUARTIC:  quartic_gain  <= cfg_data;
        CFG_REST:     rest_length   <= cfg_data[30:0];
        CFG_CUTOFF:   cutoff_length <= cfg_data[30:0];
      endcase
    end
  end

  // Advance the whole pipeline unless the result is held
  assign adv          = !vld[LAST] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[LAST];

  // Multipliers
  qbf_mul #(.A_W(32), .B_W(32)) u_mul_t1 (
    .clk(clk), .en(adv), .a(mag32(harmonic_gain)), .b(pipe[ST_DR].dr_mag), .p(p_t1)
  );
  qbf_mul #(.A_W(32), .B_W(32)) u_mul_dr2 (
    .clk(clk), .en(adv), .a(pipe[ST_DR].dr_mag), .b(pipe[ST_DR].dr_mag), .p(p_dr2)
  );
  qbf_mul #(.A_W(63), .B_W(32)) u_mul_dr3 (
    .clk(clk), .en(adv), .a(pipe[ST_M1].dr2_mag), .b(pipe[ST_M1].dr_mag), .p(p_dr3)
  );
  qbf_mul #(.A_W(63), .B_W(63)) u_mul_dr4 (
    .clk(clk), .en(adv), .a(pipe[ST_M1].dr2_mag), .b(pipe[ST_M1].dr2_mag), .p(p_dr4)
  );
  qbf_mul #(.A_W(63), .B_W(32)) u_mul_e1 (
    .clk(clk), .en(adv), .a(pipe[ST_M1].dr2_mag), .b(mag32(harmonic_gain)), .p(p_e1)
  );
  qbf_mul #(.A_W(63), .B_W(32)) u_mul_t2 (
    .clk(clk), .en(adv), .a(pipe[ST_M2].dr3_mag), .b(mag32(quartic_gain)), .p(p_t2)
  );
  qbf_mul #(.A_W(63), .B_W(32)) u_mul_e2 (
    .clk(clk), .en(adv), .a(pipe[ST_M2].dr4_mag), .b(mag32(quartic_gain)), .p(p_e2)
  );

  for (genvar c = 0; c < 3; c++) begin : g_fmul
    qbf_mul #(.A_W(63), .B_W(32)) u_mul_f (
      .clk(clk), .en(adv), .a(pipe[ST_NUM].num_mag), .b(mag32(pipe[ST_NUM].sep[c])),
      .p(p_f[c])
    );
  end

  // Next value of every stage
  always_comb begin
    logic [31:0]        m;
    logic [63:0]        x;
    logic [63:0]        r;
    logic [63:0]        b;
    logic [33:0]        drs;
    logic signed [64:0] ssum;
    logic signed [64:0] esum;
    logic [32:0]        rm;
    logic [31:0]        rq;
    logic [31:0]        qq;
    logic               qb;
    int                 n;

    m    = '0;
    x    = '0;
    r    = '0;
    b    = '0;
    drs  = '0;
    ssum = '0;
    esum = '0;
    rm   = '0;
    rq   = '0;
    qq   = '0;
    qb   = 1'b0;
    n    = 0;

    // Square the components and the cutoff
    nxt[1]        = '0;
    nxt[1].sep[0] = item.sep_x;
    nxt[1].sep[1] = item.sep_y;
    nxt[1].sep[2] = item.sep_z;
    for (int c = 0; c < 3; c++) begin
      m = mag32(nxt[1].sep[c]);
      nxt[1].sq[c] = 64'(m) * 64'(m);
    end
    nxt[1].cut2   = 62'(cutoff_length) * 62'(cutoff_length);
    nxt[1].cut_on = cutoff_length != '0;

    for (int k = 2; k <= LAST; k++) begin
      nxt[k] = pipe[k-1];

      if (k == ST_SUM) begin
        nxt[k].d2 = pipe[k-1].sq[0] + pipe[k-1].sq[1] + pipe[k-1].sq[2];
      end

      // Square root, two result bits per stage
      if (k >= ST_SQRT0 && k < ST_SQRT0 + SQRT_STAGES) begin
        if (k == ST_SQRT0) begin
          x = pipe[k-1].d2;
          r = '0;
          nxt[k].broken = pipe[k-1].cut_on && (pipe[k-1].d2 > 64'(pipe[k-1].cut2));
        end else begin
          x = pipe[k-1].sx;
          r = pipe[k-1].sres;
        end
        for (int j = 0; j < SQRT_PER; j++) begin
          n = (k - ST_SQRT0) * SQRT_PER + j;
          b = 64'(1) << (62 - 2*n);
          if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
        nxt[k].sx   = x;
        nxt[k].sres = r;
      end

      // Round the root to nearest
      if (k == ST_DIST) begin
        nxt[k].dlen = 32'(pipe[k-1].sres + 64'(pipe[k-1].sx > pipe[k-1].sres));
      end

      // Stretch against the rest length
      if (k == ST_DR) begin
        drs               = {2'b00, pipe[k-1].dlen} - {3'b000, rest_length};
        nxt[k].dr_neg     = drs[33];
        nxt[k].dr_mag     = drs[33] ? 32'(-drs) : drs[31:0];
        nxt[k].dist_zero  = pipe[k-1].dlen == '0;
      end

      if (k == ST_M1) begin
        nxt[k].t1_mag  = round_sat(128'(p_t1), SH0);
        nxt[k].t1_neg  = harmonic_gain[31] ^ pipe[k-1].dr_neg;
        nxt[k].dr2_mag = round_sat(128'(p_dr2), SH0);
      end

      if (k == ST_M2) begin
        nxt[k].dr3_mag = round_sat(128'(p_dr3), SH0);
        nxt[k].dr3_neg = pipe[k-1].dr_neg;
        nxt[k].dr4_mag = round_sat(128'(p_dr4), SH0);
        nxt[k].e1_mag  = round_sat(128'(p_e1), SH1);
        nxt[k].e1_neg  = harmonic_gain[31];
      end

      if (k == ST_M3) begin
        nxt[k].t2_mag = round_sat(128'(p_t2), SH0);
        nxt[k].t2_neg = quartic_gain[31] ^ pipe[k-1].dr3_neg;
        nxt[k].e2_mag = round_sat(128'(p_e2), SH2);
        nxt[k].e2_neg = quartic_gain[31];
      end

      // Force numerator clamped to 2^62, energy saturated to 32 bits
      if (k == ST_NUM) begin
        ssum = to_s65(pipe[k-1].t1_neg, pipe[k-1].t1_mag)
             + to_s65(pipe[k-1].t2_neg, pipe[k-1].t2_mag);
        if (ssum > $signed(65'(LIM62))) begin
          ssum = $signed(65'(LIM62));
        end else if (ssum < -$signed(65'(LIM62))) begin
          ssum = -$signed(65'(LIM62));
        end
        nxt[k].num_neg = ssum[64];
        nxt[k].num_mag = ssum[64] ? 63'(-ssum) : ssum[62:0];
        esum = to_s65(pipe[k-1].e1_neg, pipe[k-1].e1_mag)
             + to_s65(pipe[k-1].e2_neg, pipe[k-1].e2_mag);
        if (esum > $signed(65'(32'h7FFF_FFFF))) begin
          nxt[k].energy = 32'h7FFF_FFFF;
        end else if (esum < -$signed(65'(33'h0_8000_0000))) begin
          nxt[k].energy = 32'h8000_0000;
        end else begin
          nxt[k].energy = esum[31:0];
        end
      end

      // Add half the divisor for rounding
      if (k == ST_PADD) begin
        for (int c = 0; c < 3; c++) begin
          nxt[k].pf[c] = 96'(p_f[c]) + 96'(pipe[k-1].dlen >> 1);
        end
      end

      // Flag quotients of 2^32 or more, seed the divider
      if (k == ST_SAT) begin
        for (int c = 0; c < 3; c++) begin
          nxt[k].sat[c] = pipe[k-1].pf[c][95:32] >= 64'(pipe[k-1].dlen);
          nxt[k].rem[c] = pipe[k-1].pf[c][63:32];
          nxt[k].low[c] = pipe[k-1].pf[c][31:0];
          nxt[k].quo[c] = '0;
        end
      end

      // Restoring division, two quotient bits per stage
      if (k >= ST_DIV0 && k < ST_DIV0 + DIV_STAGES) begin
        for (int c = 0; c < 3; c++) begin
          rq = pipe[k-1].rem[c];
          qq = pipe[k-1].quo[c];
          for (int j = 0; j < DIV_PER; j++) begin
            n  = (k - ST_DIV0) * DIV_PER + j;
            rm = {rq, pipe[k-1].low[c][31-n]};
            qb = 1'b0;
            if (rm >= {1'b0, pipe[k-1].dlen}) begin
              rm = rm - {1'b0, pipe[k-1].dlen};
              qb = 1'b1;
            end
            rq = rm[31:0];
            qq = {qq[30:0], qb};
          end
          nxt[k].rem[c] = rq;
          nxt[k].quo[c] = qq;
        end
      end

      // Apply sign and saturate the forces; zero them when broken or at zero distance
      if (k == LAST) begin
        for (int c = 0; c < 3; c++) begin
          qq = pipe[k-1].quo[c];
          if (pipe[k-1].broken || pipe[k-1].dist_zero) begin
            nxt[k].frc[c] = '0;
          end else if (pipe[k-1].num_neg != pipe[k-1].sep[c][31]) begin
            nxt[k].frc[c] = (pipe[k-1].sat[c] || qq > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qq;
          end else begin
            if (pipe[k-1].sat[c] || qq > 32'h8000_0000) begin
              qq = 32'h8000_0000;
            end
            nxt[k].frc[c] = -qq;
          end
        end
        if (pipe[k-1].broken) begin
          nxt[k].energy = '0;
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[1] <= item_valid;
      for (int k = 2; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Advance stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= LAST; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  assign result.force_x     = pipe[LAST].frc[0];
  assign result.force_y     = pipe[LAST].frc[1];
  assign result.force_z     = pipe[LAST].frc[2];
  assign result.bond_energy = pipe[LAST].energy;
  assign result.bond_broken = pipe[LAST].broken;

endmodule

// ----- rtl/qbf_checker.sv -----
// Port-level checks for the quartic bond unit, bound to its top level.
// Depends on qbf_pkg and quartic_bond_force_energy_unit.
module qbf_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input qbf_pkg::qbf_out_t result
);
  import qbf_pkg::*;

  // Hold a stalled result item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // Take items whenever the result side is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item refused with empty pipeline");

  // Stop taking items while the result is held
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("item taken while result held");

  // Drop force and energy for a broken bond
  a_broken_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bond_broken |->
      result.force_x == 0 && result.force_y == 0 && result.force_z == 0 &&
      result.bond_energy == 0)
    else $error("broken bond with nonzero output");

endmodule

bind quartic_bond_force_energy_unit qbf_checker u_qbf_checker (.*);
